// ===== design/gsle_pkg.sv =====
// Package for the grouped sorted list engine.
// Holds sizes, field widths, command and status codes, the state type and the
// entry address function. Depends on nothing.
package gsle_pkg;

   // Storage sizes.
   localparam int GROUPS   = 8;
   localparam int CAPACITY = 32;
   localparam int DEPTH    = GROUPS * CAPACITY;

   // Request and response field widths.
   localparam int CMD_W       = 2;
   localparam int GROUP_W     = 3;
   localparam int POS_FIELD_W = 5;
   localparam int CODE_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 9;

   // Internal widths derived from the sizes.
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int GCNT_W = $clog2(GROUPS + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_PLACE,
      ST_REMOVE,
      ST_READ,
      ST_RESP
   } state_type;

   // Entry address of a position within a group.
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [GIDX_W-1:0] grp,
                                                    input logic [POS_W-1:0]  pos);
      return ADDR_W'(int'(grp) * CAPACITY + int'(pos));
   endfunction

endpackage

// ===== design/gsle_req_if.sv =====
// Request channel of the grouped sorted list engine.
// Carries valid, ready and the request fields; depends on gsle_pkg.
interface gsle_req_if;
   import gsle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [GROUP_W-1:0]       group;
   logic [POS_FIELD_W-1:0]   position;
   logic signed [CODE_W-1:0] code;

   modport source (output valid, command, group, position, code, input ready);
   modport sink   (input valid, command, group, position, code, output ready);
endinterface

// ===== design/gsle_rsp_if.sv =====
// Response channel of the grouped sorted list engine.
// Carries valid, ready and the response fields; depends on gsle_pkg.
interface gsle_rsp_if;
   import gsle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_W-1:0]       count;
   logic signed [CODE_W-1:0] read_code;

   modport source (output valid, status, count, read_code, input ready);
   modport sink   (input valid, status, count, read_code, output ready);
endinterface

// ===== design/grouped_sorted_list_engine_unit.sv =====
// Top level of the grouped sorted list engine: sequencer, entry memory and
// group length registers. Depends on gsle_pkg, gsle_req_if and gsle_rsp_if.
//
// Usage: each request on req_chan (insert, remove everywhere, or read) yields
// exactly one response on rsp_chan. Requests are taken one at a time: ready is
// high only while the sequencer is idle. All entries live in one memory with
// registered read data, so the sequencer touches one entry per cycle.
// An insert walks its group from the end, shifting larger entries up one per
// cycle (at most CAPACITY - 1 of them); a remove sweeps every stored entry of
// every group and steps past each empty group in its compaction sweep.
// The next request is taken in the cycle after a response is loaded, so a new
// request waits until the previous result has gone to the output register.
// Reset clears all group lengths, so every group starts empty; the entry
// memory is not cleared and needs no clearing pass.
// When the receiver stalls, the response waits in its output register; the
// engine finishes the next request into a holding register and then waits
// until the output register frees up.
module grouped_sorted_list_engine_unit (
   input  logic       clock,
   input  logic       reset,
   gsle_req_if.sink   req_chan,
   gsle_rsp_if.source rsp_chan
);
   import gsle_pkg::*;

   // Sequencer state.
   state_type                state_ff, state_in;
   logic [GIDX_W-1:0]        grp_ff, grp_in;
   logic signed [CODE_W-1:0] code_ff, code_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [LEN_W-1:0]         len_cur_ff, len_cur_in;

   // Removal sweep: issue stage and compare stage.
   logic [GCNT_W-1:0]        iss_grp_ff, iss_grp_in;
   logic [POS_W-1:0]         iss_pos_ff, iss_pos_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic                     cmp_last_ff, cmp_last_in;
   logic [GIDX_W-1:0]        cmp_grp_ff, cmp_grp_in;
   logic [LEN_W-1:0]         keep_ff, keep_in;
   logic [COUNT_W-1:0]       removed_ff, removed_in;

   // Finished result and output register.
   status_type               res_status_ff, res_status_in;
   logic [COUNT_W-1:0]       res_count_ff, res_count_in;
   logic signed [CODE_W-1:0] res_code_ff, res_code_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [CODE_W-1:0] rsp_code_ff, rsp_code_in;

   // Group lengths and entry memory.
   logic [LEN_W-1:0]         len_ff [GROUPS];
   logic                     len_we;
   logic [GIDX_W-1:0]        len_widx;
   logic [LEN_W-1:0]         len_wdata;
   logic [GIDX_W-1:0]        len_sel;
   logic [LEN_W-1:0]         len_rd;

   logic [CODE_W-1:0]        mem [DEPTH];
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [CODE_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]        mem_raddr;
   logic [CODE_W-1:0]        rdata_ff;

   // Decoded request and sweep conditions.
   logic                     req_fire;
   logic [GIDX_W-1:0]        req_gidx;
   logic                     req_gvalid;
   logic                     req_pos_ok;
   logic                     ins_gt;
   logic                     iss_active;
   logic                     rem_done;
   logic                     rsp_free;
   logic [LEN_W-1:0]         keep_next;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign req_gidx   = GIDX_W'(req_chan.group);
   assign req_gvalid = int'(req_chan.group) < GROUPS;
   assign ins_gt     = $signed(rdata_ff) > code_ff;
   assign iss_active = int'(iss_grp_ff) < GROUPS;
   assign rem_done   = !iss_active && !cmp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // One length read port, steered by the state.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   len_sel = req_gidx;
         ST_REMOVE: len_sel = iss_grp_ff[GIDX_W-1:0];
         default:   len_sel = grp_ff;
      endcase
   end
   assign len_rd     = len_ff[len_sel];
   assign req_pos_ok = int'(req_chan.position) < int'(len_rd);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.command)
                  CMD_INSERT: begin
                     if (!req_gvalid || len_rd >= LEN_W'(CAPACITY)) begin
                        state_in = ST_RESP;
                     end else if (len_rd == '0) begin
                        state_in = ST_PLACE;
                     end else begin
                        state_in = ST_INSERT;
                     end
                  end
                  CMD_REMOVE: state_in = ST_REMOVE;
                  CMD_READ:   state_in = (req_gvalid && req_pos_ok) ? ST_READ : ST_RESP;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_INSERT: begin
            if (!ins_gt || pos_ff == '0) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE:  state_in = ST_RESP;
         ST_REMOVE: begin
            if (rem_done) begin
               state_in = ST_RESP;
            end
         end
         ST_READ:   state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory and length controls.
   always_comb begin
      grp_in        = grp_ff;
      code_in       = code_ff;
      pos_in        = pos_ff;
      len_cur_in    = len_cur_ff;
      iss_grp_in    = iss_grp_ff;
      iss_pos_in    = iss_pos_ff;
      cmp_valid_in  = 1'b0;
      cmp_last_in   = cmp_last_ff;
      cmp_grp_in    = cmp_grp_ff;
      keep_in       = keep_ff;
      keep_next     = keep_ff;
      removed_in    = removed_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_code_in   = res_code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_code_in   = rsp_code_ff;
      len_we        = 1'b0;
      len_widx      = grp_ff;
      len_wdata     = len_cur_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = rdata_ff;
      mem_raddr     = '0;

      unique case (state_ff)
         // Take a request and start its walk, or answer it at once.
         ST_IDLE: begin
            if (req_fire) begin
               grp_in        = req_gidx;
               code_in       = req_chan.code;
               len_cur_in    = len_rd;
               res_status_in = STATUS_OK;
               res_count_in  = '0;
               res_code_in   = '0;
               unique case (req_chan.command)
                  CMD_INSERT: begin
                     if (!req_gvalid) begin
                        res_status_in = STATUS_FULL;
                     end else if (len_rd >= LEN_W'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                        res_count_in  = COUNT_W'(len_rd);
                     end else if (len_rd == '0) begin
                        pos_in = '0;
                     end else begin
                        pos_in    = POS_W'(len_rd - LEN_W'(1));
                        mem_raddr = entry_addr(req_gidx, POS_W'(len_rd - LEN_W'(1)));
                     end
                  end
                  CMD_REMOVE: begin
                     iss_grp_in = '0;
                     iss_pos_in = '0;
                     keep_in    = '0;
                     removed_in = '0;
                  end
                  CMD_READ: begin
                     if (req_gvalid && req_pos_ok) begin
                        mem_raddr = entry_addr(req_gidx, POS_W'(req_chan.position));
                     end else begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end

         // Walk down the group, moving larger entries up by one.
         ST_INSERT: begin
            if (ins_gt) begin
               mem_we    = 1'b1;
               mem_waddr = entry_addr(grp_ff, POS_W'(pos_ff + POS_W'(1)));
               mem_wdata = rdata_ff;
               if (pos_ff != '0) begin
                  pos_in    = pos_ff - POS_W'(1);
                  mem_raddr = entry_addr(grp_ff, pos_ff - POS_W'(1));
               end
            end else begin
               pos_in = POS_W'(pos_ff + POS_W'(1));
            end
         end

         // Drop the new code into the gap and grow the group.
         ST_PLACE: begin
            mem_we        = 1'b1;
            mem_waddr     = entry_addr(grp_ff, pos_ff);
            mem_wdata     = code_ff;
            len_we        = 1'b1;
            len_widx      = grp_ff;
            len_wdata     = len_cur_ff + LEN_W'(1);
            res_status_in = STATUS_OK;
            res_count_in  = COUNT_W'(len_cur_ff + LEN_W'(1));
            res_code_in   = '0;
         end

         // Compact every group: issue one read per cycle, compare in the cycle after.
         ST_REMOVE: begin
            if (iss_active) begin
               if (len_rd == '0) begin
                  iss_grp_in = iss_grp_ff + GCNT_W'(1);
                  iss_pos_in = '0;
               end else begin
                  mem_raddr    = entry_addr(iss_grp_ff[GIDX_W-1:0], iss_pos_ff);
                  cmp_valid_in = 1'b1;
                  cmp_grp_in   = iss_grp_ff[GIDX_W-1:0];
                  cmp_last_in  = (LEN_W'(iss_pos_ff) == len_rd - LEN_W'(1));
                  if (LEN_W'(iss_pos_ff) == len_rd - LEN_W'(1)) begin
                     iss_grp_in = iss_grp_ff + GCNT_W'(1);
                     iss_pos_in = '0;
                  end else begin
                     iss_pos_in = iss_pos_ff + POS_W'(1);
                  end
               end
            end
            if (cmp_valid_ff) begin
               if (rdata_ff == code_ff) begin
                  removed_in = removed_ff + COUNT_W'(1);
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = entry_addr(cmp_grp_ff, keep_ff[POS_W-1:0]);
                  mem_wdata = rdata_ff;
                  keep_next = keep_ff + LEN_W'(1);
               end
               if (cmp_last_ff) begin
                  len_we    = 1'b1;
                  len_widx  = cmp_grp_ff;
                  len_wdata = keep_next;
                  keep_in   = '0;
               end else begin
                  keep_in = keep_next;
               end
            end
            if (rem_done) begin
               res_status_in = STATUS_OK;
               res_count_in  = removed_ff;
               res_code_in   = '0;
            end
         end

         // Read data arrived from the memory.
         ST_READ: begin
            res_status_in = STATUS_OK;
            res_count_in  = '0;
            res_code_in   = rdata_ff;
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               rsp_code_in   = res_code_ff;
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_grp_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUPS; g++) begin
            len_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         iss_grp_ff   <= iss_grp_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (len_we) begin
            len_ff[len_widx] <= len_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      grp_ff        <= grp_in;
      code_ff       <= code_in;
      pos_ff        <= pos_in;
      len_cur_ff    <= len_cur_in;
      iss_pos_ff    <= iss_pos_in;
      cmp_last_ff   <= cmp_last_in;
      cmp_grp_ff    <= cmp_grp_in;
      keep_ff       <= keep_in;
      removed_ff    <= removed_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_code_ff   <= res_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_code_ff   <= rsp_code_in;
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Channel outputs.
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.read_code = rsp_code_ff;

   // An insert walk only runs on a group with room left.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (len_cur_ff < LEN_W'(CAPACITY)))
      else $error("insert walk on a full group");

   // A taken request always leaves the idle state.
   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request taken but sequencer stayed idle");

   // A read never disturbs the stored entries.
   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !mem_we)
      else $error("memory written during a read");

   // A response only appears out of the response state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("response raised outside the response state");

endmodule

// ===== bench/gsle_list_checker.sv =====
// Scoreboard for the grouped sorted list engine: watches both channels, keeps
// its own copy of every group's sorted list and checks each response in order.
// Depends on gsle_pkg, gsle_req_if and gsle_rsp_if.
module gsle_list_checker (
   input  logic clock,
   input  logic reset,
   gsle_req_if  req_chan,
   gsle_rsp_if  rsp_chan,
   input  logic summary_req,
   output int   fail_count,
   output int   pending_results
);
   import gsle_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic signed [CODE_W-1:0] read_code;
   } rsp_fields_type;

   // Shadow copy of the engine's lists and the responses still owed.
   // Entries are only read below a group's length, so they need no clearing.
   logic signed [CODE_W-1:0] list_entry [GROUPS][CAPACITY];
   int                       list_len [GROUPS];
   rsp_fields_type           expected_rsp [$];

   // Activity counters for the closing summary; they start at zero.
   int n_checked, n_insert, n_full, n_remove, copies_removed, n_read, n_range, n_unused;

   // Applies one request to the shadow lists and returns the response it owes.
   function automatic rsp_fields_type apply_request(input logic [CMD_W-1:0]       cmd,
                                                    input logic [GROUP_W-1:0]     grp,
                                                    input logic [POS_FIELD_W-1:0] pos,
                                                    input logic signed [CODE_W-1:0] code);
      rsp_fields_type r;
      int             len;
      int             at;
      int             removed;
      int             keep;
      r.status    = STATUS_OK;
      r.count     = '0;
      r.read_code = '0;
      case (cmd)
         CMD_INSERT: begin
            n_insert++;
            if (int'(grp) >= GROUPS) begin
               r.status = STATUS_FULL;
            end else begin
               len = list_len[grp];
               if (len >= CAPACITY) begin
                  r.status = STATUS_FULL;
                  r.count  = COUNT_W'(len);
               end else begin
                  // New code goes after every entry that is not greater.
                  at = 0;
                  while (at < len && !(list_entry[grp][at] > code)) at++;
                  for (int i = len; i > at; i--)
                     list_entry[grp][i] = list_entry[grp][i-1];
                  list_entry[grp][at] = code;
                  list_len[grp]       = len + 1;
                  r.count             = COUNT_W'(len + 1);
               end
            end
            if (r.status == STATUS_FULL) n_full++;
         end
         CMD_REMOVE: begin
            // Compact every group, dropping all copies of the code.
            n_remove++;
            removed = 0;
            for (int g = 0; g < GROUPS; g++) begin
               keep = 0;
               for (int i = 0; i < list_len[g]; i++) begin
                  if (list_entry[g][i] == code) begin
                     removed++;
                  end else begin
                     list_entry[g][keep] = list_entry[g][i];
                     keep++;
                  end
               end
               list_len[g] = keep;
            end
            copies_removed += removed;
            r.count = COUNT_W'(removed);
         end
         CMD_READ: begin
            n_read++;
            if (int'(grp) >= GROUPS || int'(pos) >= list_len[grp]) begin
               r.status = STATUS_RANGE;
               n_range++;
            end else begin
               r.read_code = list_entry[grp][pos];
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      return r;
   endfunction

   // Responses are checked before the request of the same edge is predicted;
   // no response can belong to a request accepted at that same edge.
   // Reports give status, count and read code in that order.
   always @(posedge clock) begin
      rsp_fields_type want;
      if (reset) begin
         foreach (list_len[g]) list_len[g] = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_checked++;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("response %0d with none owed: got %0d/%0d/%0d",
                           n_checked, rsp_chan.status, rsp_chan.count, rsp_chan.read_code);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_chan.status !== want.status || rsp_chan.count !== want.count ||
                   rsp_chan.read_code !== want.read_code) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("response %0d mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              n_checked, want.status, want.count, want.read_code,
                              rsp_chan.status, rsp_chan.count, rsp_chan.read_code);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_rsp.push_back(apply_request(req_chan.command, req_chan.group,
                                                 req_chan.position, req_chan.code));
      end
      pending_results = expected_rsp.size();
   end

   // Closing summary of what the run exercised.
   always @(posedge summary_req) begin
      $display("Checked %0d responses with %0d mismatches: %0d inserts (%0d refused as full),",
               n_checked, fail_count, n_insert, n_full);
      $display("%0d removes taking %0d copies, %0d reads (%0d out of range), %0d unused.",
               n_remove, copies_removed, n_read, n_range, n_unused);
   end

endmodule

// ===== bench/tb_grouped_sorted_list_engine_unit.sv =====
// Testbench top for the grouped sorted list engine: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on gsle_pkg, the
// channel interfaces, grouped_sorted_list_engine_unit and gsle_list_checker.
module tb_grouped_sorted_list_engine_unit;
   import gsle_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int ITEM_GOAL      = 650;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 3 + GROUPS + DEPTH + 20;
   localparam int TIMEOUT_CYCLES = 1_200_000;

   localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
   localparam logic signed [CODE_W-1:0] CODE_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [CODE_W-1:0] CODE_MIN  = 32'sh8000_0000;

   logic clock;
   logic reset;
   logic summary_req;
   int   fail_count;
   int   pending_results;
   int   items_sent;
   bit   sender_gaps;
   bit   hold_off_req;

   gsle_req_if req_chan ();
   gsle_rsp_if rsp_chan ();

   grouped_sorted_list_engine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   gsle_list_checker list_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .summary_req     (summary_req),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Safety net against a hung engine.
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("tb_grouped_sorted_list_engine_unit: FAIL");
      $finish;
   end

   // Mostly short idle gaps between requests, now and then a long one.
   function automatic int idle_gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Codes lean on a small pool so that duplicates and removals hit often.
   function automatic logic signed [CODE_W-1:0] pick_code();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return CODE_MAX;
      if (r == 1) return CODE_MIN;
      if (r < 7) return CODE_W'($signed($urandom_range(0, 15)) - 8);
      return $urandom();
   endfunction

   // Offers one request at a falling edge and holds it until it is taken.
   task automatic send_request(input logic [CMD_W-1:0]         cmd,
                               input logic [GROUP_W-1:0]       grp,
                               input logic [POS_FIELD_W-1:0]   pos,
                               input logic signed [CODE_W-1:0] code);
      int gap;
      req_chan.valid    <= 1'b1;
      req_chan.command  <= cmd;
      req_chan.group    <= grp;
      req_chan.position <= pos;
      req_chan.code     <= code;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      items_sent++;
      @(negedge clock);
      gap = sender_gaps ? idle_gap_cycles() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // One request with every field random.
   task automatic send_random_item();
      int                 r;
      logic [CMD_W-1:0]   cmd;
      r = $urandom_range(0, 19);
      if (r < 9)       cmd = CMD_INSERT;
      else if (r < 11) cmd = CMD_REMOVE;
      else if (r < 19) cmd = CMD_READ;
      else             cmd = CMD_UNUSED;
      send_request(cmd, GROUP_W'($urandom_range(0, GROUPS - 1)),
                   POS_FIELD_W'($urandom_range(0, 31)),
                   ($urandom_range(0, 1) == 0) ? pick_code() : $signed($urandom()));
   endtask

   // Stops offering until every outstanding request has its response.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   // Response back-pressure: runs of ready high and low, plus one long hold.
   initial begin
      int hold_left;
      int run_left;
      bit run_high;
      rsp_chan.ready = 1'b0;
      hold_left      = 0;
      run_left       = 0;
      run_high       = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_chan.ready <= run_high;
         end else begin
            run_high = !run_high;
            if (run_high)
               run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
            else if ($urandom_range(0, 19) < 16)
               run_left = $urandom_range(1, 3);
            else if ($urandom_range(0, 3) < 3)
               run_left = $urandom_range(4, 12);
            else
               run_left = $urandom_range(20, 60);
            run_left--;
            rsp_chan.ready <= run_high;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [GROUP_W-1:0] grp;
      int                 n;
      bit                 paused_mid;
      req_chan.valid    = 1'b0;
      req_chan.command  = CMD_INSERT;
      req_chan.group    = '0;
      req_chan.position = '0;
      req_chan.code     = '0;
      reset             = 1'b1;
      summary_req       = 1'b0;
      items_sent        = 0;
      sender_gaps       = 1'b1;
      hold_off_req      = 1'b0;
      paused_mid        = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extreme codes, duplicates, reads in and out of range,
      // removal of present and absent codes, and the unused command.
      send_request(CMD_INSERT, 3'd0, 5'd0, 32'sd0);
      send_request(CMD_INSERT, 3'd0, 5'd0, CODE_MAX);
      send_request(CMD_INSERT, 3'd0, 5'd0, CODE_MIN);
      send_request(CMD_INSERT, 3'd0, 5'd0, -32'sd1);
      send_request(CMD_INSERT, 3'd0, 5'd0, 32'sd0);
      send_request(CMD_INSERT, 3'd7, 5'd0, 32'sh5555_5555);
      send_request(CMD_INSERT, 3'd7, 5'd0, 32'shAAAA_AAAA);
      for (int p = 0; p < 6; p++) send_request(CMD_READ, 3'd0, POS_FIELD_W'(p), 32'sd0);
      send_request(CMD_READ, 3'd3, 5'd31, 32'sd0);
      send_request(CMD_READ, 3'd7, 5'd1, 32'sd0);
      send_request(CMD_REMOVE, 3'd0, 5'd0, 32'sd0);
      send_request(CMD_REMOVE, 3'd5, 5'd0, 32'sd12345);
      send_request(CMD_UNUSED, 3'd7, 5'd31, -32'sd1);
      send_request(CMD_READ, 3'd0, 5'd0, 32'sd0);
      send_request(CMD_REMOVE, 3'd0, 5'd0, CODE_MIN);
      send_request(CMD_INSERT, 3'd5, 5'd0, 32'sd7);
      send_request(CMD_INSERT, 3'd5, 5'd0, 32'sd7);
      send_request(CMD_READ, 3'd5, 5'd1, 32'sd0);
      drain_responses();

      // Overfill one group back to back while the receiver holds off, so the
      // engine backs up and stalls its request side.
      hold_off_req = 1'b1;
      sender_gaps  = 1'b0;
      repeat (CAPACITY + 2) send_request(CMD_INSERT, 3'd2, 5'd0, pick_code());

      // Random segments: fill bursts, read sweeps, removal bursts and mixed
      // traffic, with one full pause halfway through.
      while (items_sent < ITEM_GOAL) begin
         if (!paused_mid && items_sent >= ITEM_GOAL / 2) begin
            drain_responses();
            paused_mid = 1'b1;
         end
         sender_gaps = ($urandom_range(0, 9) < 7);
         grp         = GROUP_W'($urandom_range(0, GROUPS - 1));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = $urandom_range(8, 36);
               repeat (n) send_request(CMD_INSERT, grp, POS_FIELD_W'($urandom_range(0, 31)),
                                       pick_code());
            end
            3: begin
               n = $urandom_range(4, 32);
               for (int p = 0; p < n; p++)
                  send_request(CMD_READ, grp, POS_FIELD_W'(p), $signed($urandom()));
            end
            4: begin
               repeat ($urandom_range(2, 6))
                  send_request(CMD_REMOVE, GROUP_W'($urandom_range(0, GROUPS - 1)),
                               POS_FIELD_W'($urandom_range(0, 31)), pick_code());
            end
            default: begin
               repeat ($urandom_range(5, 20)) send_random_item();
            end
         endcase
      end

      // Let the last responses arrive and watch for strays.
      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      summary_req = 1'b1;
      @(negedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("tb_grouped_sorted_list_engine_unit: PASS");
      else
         $display("tb_grouped_sorted_list_engine_unit: FAIL");
      $finish;
   end

endmodule
